### rtl/length_confirmed_frame_sync_unit_assert.svh
// Assertion shorthands for the frame sync unit.
// Both expect clk and arst_n in the enclosing scope.
`ifndef LENGTH_CONFIRMED_FRAME_SYNC_UNIT_ASSERT_SVH
`define LENGTH_CONFIRMED_FRAME_SYNC_UNIT_ASSERT_SVH

// same-cycle implication
`define LCFS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcfs assertion failed");

// next-cycle implication
`define LCFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcfs assertion failed");

`endif

### rtl/lcfs_pkg.sv
`default_nettype none

package lcfs_pkg;

	localparam int HEADER_BYTES_DEF  = 4;
	localparam int TRAILER_BYTES_DEF = 4;
	localparam int LENGTH_BYTES      = 4;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam int LEN_W = 24;
	localparam int LIM_W = 25;
	localparam logic [LEN_W-1:0] LEN_SAT   = 24'hFF_FFFF;
	localparam logic [LIM_W-1:0] LIMIT_CAP = 25'h100_0000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd3;

	localparam logic [7:0]       PERM_RESET   = 8'd228;
	localparam logic [LIM_W-1:0] MAXLEN_RESET = 25'd16384;

	typedef enum logic [2:0] {
		EV_PAYLOAD     = 3'd0,
		EV_GOOD        = 3'd1,
		EV_TRAILER_BAD = 3'd2,
		EV_COPY_BAD    = 3'd3,
		EV_OVERSIZE    = 3'd4
	} ev_kind_t;

	typedef struct packed {
		logic [31:0]      header;
		logic [31:0]      trailer;
		logic [7:0]       perm;
		logic [LIM_W-1:0] max_len;
	} cfg_regs_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} q_head_t;

	// pattern byte at a position; positions past the 32-bit register read as zero
	function automatic logic [7:0] pat_byte(input logic [31:0] pat, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (!idx[2]) begin
			r = pat[{idx[1:0], 3'b000} +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/lcfs_if.sv
`default_nettype none

interface lcfs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcfs_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [23:0] frame_length;
	modport source (output valid, output event_kind, output payload_byte,
		output frame_length, input ready);
	modport sink (input valid, input event_kind, input payload_byte,
		input frame_length, output ready);
endinterface

interface lcfs_cfg_if import lcfs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/lcfs_in_queue.sv
`default_nettype none

module lcfs_in_queue import lcfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lcfs_byte_if.sink     rx,
	input  wire logic     pop,
	output q_head_t       head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    buf_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;

	assign rx.ready   = (cnt_q != CW'(DEPTH));
	assign push       = rx.valid && rx.ready;
	assign head.valid = (cnt_q != '0);
	assign head.data  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lcfs_engine.sv
`default_nettype none
`include "length_confirmed_frame_sync_unit_assert.svh"

module lcfs_engine import lcfs_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_regs_t cfg,
	input  wire q_head_t   head,
	output logic           pop,
	lcfs_event_if.source   ev
);

	localparam int HM_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam int FC_MAX = (TRAILER_BYTES > LENGTH_BYTES) ? TRAILER_BYTES : LENGTH_BYTES;
	localparam int FC_W   = $clog2(FC_MAX);

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_LEN     = 5'b00010,
		PH_COPY    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_TRAILER = 5'b10000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [HM_W-1:0]   hm_q, hm_d;
	logic [FC_W-1:0]   fcnt_q, fcnt_d;
	logic              tr_ok_q, tr_ok_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  copy_q, copy_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [7:0]        store_q [8];
	logic              rp_active_q;
	logic [2:0]        rp_idx_q;

	logic              ov_q;
	ev_kind_t          okind_q;
	logic [7:0]        obyte_q;
	logic [LEN_W-1:0]  olen_q;

	logic              out_free, step_norm, step;
	logic [7:0]        b;
	logic              fire;
	ev_kind_t          kind_d;
	logic [7:0]        ebyte_d;
	logic [LEN_W-1:0]  elen_d;
	logic              rp_start;
	logic              st_we;
	logic [2:0]        st_wa;
	logic [LIM_W-1:0]  lim;
	logic [31:0]       len_full, copy_full;
	logic              copy_match;
	logic              tr_hit;

	assign out_free  = !ov_q || ev.ready;
	assign step_norm = !rp_active_q && head.valid && out_free;
	assign step      = rp_active_q || step_norm;
	assign pop       = step_norm;
	// replayed bytes come back out of the held store
	assign b         = rp_active_q ? store_q[rp_idx_q] : head.data;
	assign lim       = (cfg.max_len > LIMIT_CAP) ? LIMIT_CAP : cfg.max_len;
	assign len_full  = {8'h00, len_q};
	assign copy_full = {b, copy_q};
	assign tr_hit    = tr_ok_q && (b == pat_byte(cfg.trailer, 3'(fcnt_q)));

	always_comb begin
		copy_match = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (copy_full[{cfg.perm[2*i +: 2], 3'b000} +: 8] != len_full[8*i +: 8]) begin
				copy_match = 1'b0;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hm_d     = hm_q;
		fcnt_d   = fcnt_q;
		tr_ok_d  = tr_ok_q;
		len_d    = len_q;
		copy_d   = copy_q;
		rem_d    = rem_q;
		fire     = 1'b0;
		kind_d   = EV_PAYLOAD;
		ebyte_d  = 8'h00;
		elen_d   = '0;
		rp_start = 1'b0;
		st_we    = 1'b0;
		st_wa    = 3'd0;
		case (phase_q)
			PH_HUNT: begin
				if (b == pat_byte(cfg.header, 3'(hm_q))) begin
					if (hm_q == HM_W'(HEADER_BYTES - 1)) begin
						phase_d = PH_LEN;
						fcnt_d  = '0;
						hm_d    = '0;
					end else begin
						hm_d = hm_q + HM_W'(1);
					end
				end else begin
					hm_d = '0;
				end
			end
			PH_LEN: begin
				st_we  = 1'b1;
				st_wa  = {1'b0, fcnt_q[1:0]};
				fcnt_d = fcnt_q + FC_W'(1);
				if (fcnt_q[1:0] == 2'd3) begin
					if ((b != 8'h00) || ({1'b0, len_q} >= lim)) begin
						fire    = 1'b1;
						kind_d  = EV_OVERSIZE;
						elen_d  = (b != 8'h00) ? LEN_SAT : len_q;
						phase_d = PH_HUNT;
						hm_d    = '0;
						fcnt_d  = '0;
					end else begin
						phase_d = PH_COPY;
						fcnt_d  = '0;
					end
				end else begin
					len_d[{fcnt_q[1:0], 3'b000} +: 8] = b;
				end
			end
			PH_COPY: begin
				st_we  = 1'b1;
				st_wa  = {1'b1, fcnt_q[1:0]};
				fcnt_d = fcnt_q + FC_W'(1);
				if (fcnt_q[1:0] == 2'd3) begin
					fcnt_d = '0;
					if (!copy_match) begin
						fire     = 1'b1;
						kind_d   = EV_COPY_BAD;
						elen_d   = len_q;
						phase_d  = PH_HUNT;
						hm_d     = '0;
						rp_start = 1'b1;
					end else begin
						rem_d   = len_q;
						tr_ok_d = 1'b1;
						phase_d = (len_q == '0) ? PH_TRAILER : PH_PAYLOAD;
					end
				end else begin
					copy_d[{fcnt_q[1:0], 3'b000} +: 8] = b;
				end
			end
			PH_PAYLOAD: begin
				fire    = 1'b1;
				kind_d  = EV_PAYLOAD;
				ebyte_d = b;
				rem_d   = rem_q - LEN_W'(1);
				if (rem_q == LEN_W'(1)) begin
					phase_d = PH_TRAILER;
					fcnt_d  = '0;
					tr_ok_d = 1'b1;
				end
			end
			PH_TRAILER: begin
				tr_ok_d = tr_hit;
				fcnt_d  = fcnt_q + FC_W'(1);
				if (fcnt_q == FC_W'(TRAILER_BYTES - 1)) begin
					fire    = 1'b1;
					kind_d  = tr_hit ? EV_GOOD : EV_TRAILER_BAD;
					elen_d  = len_q;
					phase_d = PH_HUNT;
					hm_d    = '0;
					fcnt_d  = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				hm_d    = '0;
				fcnt_d  = '0;
			end
		endcase
	end

	// held length/copy bytes; a replay only overwrites entries it has already read
	always_ff @(posedge clk) begin
		if (step && st_we) begin
			store_q[st_wa] <= b;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			len_d_hold: begin
				len_q  <= len_d;
				copy_q <= copy_d;
				rem_q  <= rem_d;
			end
		end
		if (step_norm && fire) begin
			okind_q <= kind_d;
			obyte_q <= ebyte_d;
			olen_q  <= elen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			hm_q        <= '0;
			fcnt_q      <= '0;
			tr_ok_q     <= 1'b0;
			rp_active_q <= 1'b0;
			rp_idx_q    <= '0;
			ov_q        <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				hm_q    <= hm_d;
				fcnt_q  <= fcnt_d;
				tr_ok_q <= tr_ok_d;
			end
			if (rp_active_q) begin
				if ((fire && (kind_d == EV_OVERSIZE)) || (rp_idx_q == 3'd7)) begin
					rp_active_q <= 1'b0;
					rp_idx_q    <= '0;
				end else begin
					rp_idx_q <= rp_idx_q + 3'd1;
				end
			end else if (step_norm && rp_start) begin
				rp_active_q <= 1'b1;
				rp_idx_q    <= '0;
			end
			if (step_norm && fire) begin
				ov_q <= 1'b1;
			end else if (ev.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign ev.valid        = ov_q;
	assign ev.event_kind   = okind_q;
	assign ev.payload_byte = obyte_q;
	assign ev.frame_length = olen_q;

	// eight held bytes cannot carry a header, length and full copy
	`LCFS_ASSERT_NOW(a_rp_phase, rp_active_q,
		(phase_q == PH_HUNT) || (phase_q == PH_LEN) || (phase_q == PH_COPY))
	`LCFS_ASSERT_NOW(a_rp_from_copy, $rose(rp_active_q), $past(phase_q) == PH_COPY)
	`LCFS_ASSERT_NOW(a_rp_idx_idle, !rp_active_q, rp_idx_q == 3'd0)
	`LCFS_ASSERT_NEXT(a_rp_event, step_norm && rp_start,
		rp_active_q && ov_q && (okind_q == EV_COPY_BAD))

endmodule

`default_nettype wire

### rtl/length_confirmed_frame_sync_unit.sv
// A byte accepted on rx passes through the queue, then the output register,
// before its word shows on ev.
// Throughput: one byte per cycle while ev keeps taking words.
// A copy mismatch stops the engine popping the queue while the eight held bytes rescan.
// Reset (arst_n low, async): hunting for header, input queue empty, no word pending,
// config registers back to header 0, trailer 0, permutation 228, limit 16384.
`default_nettype none

module length_confirmed_frame_sync_unit import lcfs_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lcfs_byte_if.sink    rx,
	lcfs_event_if.source ev,
	lcfs_cfg_if.sink     cfg
);

	// Config registers. The user writes only while the unit is idle (the block does not enforce it); no shadowing.
	cfg_regs_t cfg_q;
	q_head_t   head;
	logic      pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header  <= '0;
			cfg_q.trailer <= '0;
			cfg_q.perm    <= PERM_RESET;
			cfg_q.max_len <= MAXLEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_HEADER:  cfg_q.header  <= cfg.data;
				CFG_TRAILER: cfg_q.trailer <= cfg.data;
				CFG_PERM:    cfg_q.perm    <= cfg.data[7:0];
				CFG_MAXLEN:  cfg_q.max_len <= cfg.data[LIM_W-1:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// Front: byte queue. While not full it keeps taking bytes while the back end waits
	// on ev or is busy rescanning.
	lcfs_in_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.pop    (pop),
		.head   (head)
	);

	// Back: header hunt, length/copy check, payload pass-through, trailer
	// compare, replay of the eight held bytes, and the output register.
	lcfs_engine #(
		.HEADER_BYTES  (HEADER_BYTES),
		.TRAILER_BYTES (TRAILER_BYTES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.ev     (ev)
	);

endmodule

`default_nettype wire
